// ===== rtl/core/mbs_pkg.sv =====
// Shared types, constants and CRC helper for the Modbus holding-register slave.
package mbs_pkg;
  localparam int TABLE_DEPTH_DEF   = 256;
  localparam int MAX_READ_REGS_DEF = 16;
  localparam int FRAME_BYTES_DEF   = 64;

  localparam logic [1:0] ACT_FRAME = 2'd0;
  localparam logic [1:0] ACT_HWR   = 2'd1;
  localparam logic [1:0] ACT_HRD   = 2'd2;

  localparam logic [1:0] KIND_RESP  = 2'd0;
  localparam logic [1:0] KIND_UNSUP = 2'd1;
  localparam logic [1:0] KIND_HOST  = 2'd2;

  localparam logic [7:0] FN_READ   = 8'h03;
  localparam logic [7:0] FN_WRONE  = 8'h06;
  localparam logic [7:0] FN_WRMULT = 8'h10;
  localparam logic [7:0] EXC_ADDR  = 8'h02;
  localparam logic [7:0] EXC_VALUE = 8'h03;

  localparam logic CFG_SLAVE_ADDR = 1'b0;
  localparam logic CFG_ACTIVE     = 1'b1;

  // controller to datapath commands
  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_TAKE = 3'd1;
  localparam logic [2:0] CMD_RUN  = 3'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  rx_byte;
    logic        end_of_frame;
    logic [7:0]  host_index;
    logic [15:0] host_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic [15:0] read_value;
  } out_item_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction
endpackage

// ===== rtl/core/mbs_if.sv =====
// Valid/ready channel interface carrying one item.
interface mbs_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/modbus_rtu_holding_register_slave_top.sv =====
// Top level of the Modbus RTU holding-register slave (functions 03, 06, 16).
// Sequence: a plain frame byte or host write is taken directly; an end-of-frame byte
//   starts a header fetch and checks (or an unsupported notice instead), then the
//   registers stored by function 16, the response bytes with a table wait before each
//   register read, and two CRC bytes; a host read fetches its table entry.
//   Each job ends before the controller returns to idle and takes the next item.
// Throughput: one item per cycle for frame bytes and host writes while idle and not
//   clearing, one frame at a time otherwise; output stalls hold the sequencer.
// Reset: synchronous active-low; afterwards a clearing pass zeroes the holding
//   table, during which no item is accepted.
module modbus_rtu_holding_register_slave_top #(
  parameter int TABLE_DEPTH   = mbs_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_READ_REGS = mbs_pkg::MAX_READ_REGS_DEF,
  parameter int FRAME_BYTES   = mbs_pkg::FRAME_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mbs_if.sink   in_ch,
  mbs_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data
);
  import mbs_pkg::*;
  logic [7:0] slave_addr_r;
  logic [8:0] active_r;
  logic [2:0] cmd;
  logic job_done, clearing, rdy;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'd1; active_r <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDR: slave_addr_r <= cfg_data[7:0];
        CFG_ACTIVE:     active_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mbs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(rdy),
    .out_busy(clearing), .action(in_ch.data.action), .eof(in_ch.data.end_of_frame),
    .job_done, .cmd
  );
  assign in_ch.ready = rdy;

  mbs_dp #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_READ_REGS(MAX_READ_REGS),
           .FRAME_BYTES(FRAME_BYTES)) u_dp (
    .clk, .rst_n, .cmd, .in_d(in_ch.data), .slave_address(slave_addr_r),
    .active_registers(active_r), .job_done, .clearing,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_d(out_ch.data)
  );

  a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ch.ready) else $error("item taken during clear");
  a_host_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.kind == KIND_HOST) |-> out_ch.data.last_byte)
    else $error("host read not last");
endmodule

// ===== rtl/core/mbs_ctrl.sv =====
// Controller state machine for the slave: sequences frame checks and responses.
module mbs_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_busy,
  input  logic [1:0] action,
  input  logic eof,
  input  logic job_done,
  output logic [2:0] cmd
);
  import mbs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && !out_busy;

  always_comb begin
    state_nxt = state_r;
    cmd = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd = CMD_TAKE;
          if ((action == ACT_FRAME && eof) || action == ACT_HRD) state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd = CMD_RUN;
        if (job_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

// ===== rtl/core/mbs_dp.sv =====
// Datapath: frame buffer, holding table, CRC and response sequencer.
module mbs_dp #(
  parameter int TABLE_DEPTH   = mbs_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_READ_REGS = mbs_pkg::MAX_READ_REGS_DEF,
  parameter int FRAME_BYTES   = mbs_pkg::FRAME_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic [2:0] cmd,
  input  mbs_pkg::in_item_t in_d,
  input  logic [7:0] slave_address,
  input  logic [8:0] active_registers,
  output logic job_done,
  output logic clearing,
  output logic out_valid,
  input  logic out_ready,
  output mbs_pkg::out_item_t out_d
);
  import mbs_pkg::*;
  localparam int FW = $clog2(FRAME_BYTES + 1);
  localparam int FA = $clog2(FRAME_BYTES);
  localparam int TA = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TC = $clog2(TABLE_DEPTH + 1);

  // sequencer phases
  localparam logic [3:0] P_START  = 4'd0;
  localparam logic [3:0] P_HDR    = 4'd1;
  localparam logic [3:0] P_CHK    = 4'd2;
  localparam logic [3:0] P_WRLO   = 4'd3;
  localparam logic [3:0] P_WRM    = 4'd4;
  localparam logic [3:0] P_EMIT   = 4'd5;
  localparam logic [3:0] P_CRC    = 4'd6;
  localparam logic [3:0] P_DONE   = 4'd7;
  localparam logic [3:0] P_HRD    = 4'd8;
  localparam logic [3:0] P_FETCH  = 4'd9;
  localparam logic [3:0] P_WAIT   = 4'd10;
  localparam logic [3:0] P_UNSUP  = 4'd11;

  // response modes
  localparam logic [1:0] M_EXC  = 2'd0;
  localparam logic [1:0] M_READ = 2'd1;
  localparam logic [1:0] M_ECHO = 2'd2;

  localparam logic [TC+8:0] EL_EXC  = (TC+9)'(3);
  localparam logic [TC+8:0] EL_ECHO = (TC+9)'(6);

  logic [7:0]  fbuf [FRAME_BYTES];
  logic [15:0] tbl [TABLE_DEPTH];
  logic [FW-1:0] fill_r;
  logic ovf_r;
  logic [15:0] crc_r;
  logic [TA:0] clr_r;
  assign clearing = !clr_r[TA];

  logic [3:0] ph_r;
  logic [7:0] hdr_r [7];
  logic [2:0] hi_r;
  logic [FA-1:0] fa_r;
  logic [7:0] frd_r;
  logic [15:0] trd_r;
  logic [15:0] tx_crc_r;
  logic [7:0] func_r, exc_r;
  logic [1:0] mode_r;
  logic [15:0] cnt_r, first_r;
  logic [TC+8:0] emit_r, elen_r;
  logic [7:0] hostidx_r;
  logic [7:0] wrhi_r;

  logic       fb_we, tb_we;
  logic [FA-1:0] fb_wa;
  logic [7:0] fb_wd;
  logic [TA-1:0] tb_wa, tb_ra;
  logic [15:0] tb_wd;
  logic [FA-1:0] fb_ra;

  always_ff @(posedge clk) begin
    if (fb_we) fbuf[fb_wa] <= fb_wd;
    frd_r <= fbuf[fb_ra];
    if (tb_we) tbl[tb_wa] <= tb_wd;
    trd_r <= tbl[tb_ra];
  end

  logic [16:0] lim;
  assign lim = (17'(active_registers) < 17'(TABLE_DEPTH)) ? 17'(active_registers)
                                                         : 17'(TABLE_DEPTH);
  logic bcast;
  assign bcast = hdr_r[0] == 8'h00;
  logic [9:0] fill9;
  assign fill9 = 10'd9 + 10'(hdr_r[6]);

  logic [7:0] nbyte;

  always_comb begin
    fb_we = cmd == CMD_TAKE && in_d.action == ACT_FRAME && fill_r < FW'(FRAME_BYTES);
    fb_wa = fill_r[FA-1:0];
    fb_wd = in_d.rx_byte;
    fb_ra = fa_r;
    tb_we = 1'b0; tb_wa = clr_r[TA-1:0]; tb_wd = 16'h0;
    // data bytes start at index 3, two per register
    tb_ra = first_r[TA-1:0] + TA'((emit_r - 3) >> 1);
    if (!clr_r[TA]) begin
      tb_we = 1'b1;
    end else if (cmd == CMD_TAKE && in_d.action == ACT_HWR &&
                 32'(in_d.host_index) < TABLE_DEPTH) begin
      tb_we = 1'b1; tb_wa = TA'(in_d.host_index); tb_wd = in_d.host_value;
    end else if (ph_r == P_WRLO) begin
      tb_we = 1'b1; tb_wa = first_r[TA-1:0]; tb_wd = cnt_r;
    end else if (ph_r == P_WRM && hi_r == 3'd1) begin
      tb_we = 1'b1; tb_wa = first_r[TA-1:0] + TA'(emit_r); tb_wd = {wrhi_r, frd_r};
    end
    if (ph_r == P_HRD || ph_r == P_FETCH) tb_ra = TA'(hostidx_r);
    // response byte select
    nbyte = 8'h00;
    case (mode_r)
      M_EXC: nbyte = (emit_r == 0) ? slave_address : (emit_r == 1) ? (func_r | 8'h80) : exc_r;
      M_READ: nbyte = (emit_r == 0) ? slave_address : (emit_r == 1) ? func_r :
                      (emit_r == 2) ? 8'(cnt_r << 1) : (emit_r[0] ? trd_r[15:8] : trd_r[7:0]);
      default: nbyte = (emit_r == 0) ? slave_address : hdr_r[3'(emit_r)];
    endcase
  end

  logic go;
  assign go = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    job_done <= 1'b0;
    if (out_valid && out_ready) out_valid <= 1'b0;
    if (!clr_r[TA]) clr_r <= clr_r + 1'b1;
    if (cmd == CMD_TAKE) begin
      if (in_d.action == ACT_FRAME) begin
        if (fill_r < FW'(FRAME_BYTES)) fill_r <= fill_r + 1'b1;
        else ovf_r <= 1'b1;
        crc_r <= crc_byte(crc_r, in_d.rx_byte);
        if (in_d.end_of_frame) begin ph_r <= P_START; fa_r <= '0; hi_r <= '0; end
      end else if (in_d.action == ACT_HRD) begin
        hostidx_r <= in_d.host_index; ph_r <= P_HRD;
      end
    end
    if (cmd == CMD_RUN) begin
      unique case (ph_r)
        P_HRD: ph_r <= P_FETCH;
        P_FETCH: if (go) begin
          out_valid <= 1'b1;
          out_d <= '{KIND_HOST, 8'h00, 1'b1,
                     (32'(hostidx_r) < TABLE_DEPTH) ? trd_r : 16'h0};
          job_done <= 1'b1; ph_r <= P_DONE;
        end
        P_START: begin ph_r <= P_HDR; fa_r <= fa_r + 1'b1; end
        P_HDR: begin
          // load first seven buffer bytes, one per cycle
          hdr_r[hi_r] <= frd_r;
          if (hi_r == 3'd6) ph_r <= P_CHK;
          hi_r <= hi_r + 1'b1;
          fa_r <= fa_r + 1'b1;
        end
        P_CHK: begin
          func_r <= hdr_r[1];
          first_r <= {hdr_r[2], hdr_r[3]};
          cnt_r <= {hdr_r[4], hdr_r[5]};
          emit_r <= '0; tx_crc_r <= 16'hFFFF;
          ph_r <= P_DONE; job_done <= 1'b1;
          if (ovf_r || fill_r < FW'(2)) begin
            // drop overflowed or short frame
          end else if (hdr_r[1] != FN_READ && hdr_r[1] != FN_WRONE &&
                       hdr_r[1] != FN_WRMULT) begin
            ph_r <= P_UNSUP; job_done <= 1'b0;
          end else if ((hdr_r[1] == FN_WRMULT) ?
                       (fill_r < FW'(7) || 10'(fill_r) != fill9) : (fill_r != FW'(8))) begin
            // drop on length mismatch
          end else if (crc_r != 16'h0) begin
            // drop on bad CRC
          end else if (hdr_r[1] == FN_READ) begin
            if (!bcast) begin
              job_done <= 1'b0; ph_r <= P_EMIT;
              if ({hdr_r[4], hdr_r[5]} == 0 ||
                  {hdr_r[4], hdr_r[5]} > 16'(MAX_READ_REGS)) begin
                mode_r <= M_EXC; exc_r <= EXC_VALUE; elen_r <= EL_EXC;
              end else if (17'({hdr_r[2], hdr_r[3]}) + 17'({hdr_r[4], hdr_r[5]}) > lim) begin
                mode_r <= M_EXC; exc_r <= EXC_ADDR; elen_r <= EL_EXC;
              end else begin
                mode_r <= M_READ; elen_r <= (TC+9)'(3 + 2 * {hdr_r[4], hdr_r[5]});
              end
            end
          end else if (hdr_r[1] == FN_WRONE) begin
            job_done <= 1'b0;
            if (17'({hdr_r[2], hdr_r[3]}) >= lim) begin
              mode_r <= M_EXC; exc_r <= EXC_ADDR; elen_r <= EL_EXC;
              ph_r <= P_EMIT; if (bcast) begin ph_r <= P_DONE; job_done <= 1'b1; end
            end else begin
              mode_r <= M_ECHO; elen_r <= EL_ECHO; ph_r <= P_WRLO;
            end
          end else begin
            job_done <= 1'b0;
            if ({hdr_r[4], hdr_r[5]} == 0 ||
                17'(hdr_r[6]) != 17'({hdr_r[4], hdr_r[5]}) * 2) begin
              mode_r <= M_EXC; exc_r <= EXC_VALUE; elen_r <= EL_EXC; ph_r <= P_EMIT;
              if (bcast) begin ph_r <= P_DONE; job_done <= 1'b1; end
            end else if (17'({hdr_r[2], hdr_r[3]}) + 17'({hdr_r[4], hdr_r[5]}) > lim) begin
              mode_r <= M_EXC; exc_r <= EXC_ADDR; elen_r <= EL_EXC; ph_r <= P_EMIT;
              if (bcast) begin ph_r <= P_DONE; job_done <= 1'b1; end
            end else begin
              mode_r <= M_ECHO; elen_r <= EL_ECHO; ph_r <= P_WRM;
              fa_r <= FA'(7); hi_r <= 3'd0;
            end
          end
        end
        P_UNSUP: if (go) begin
          out_valid <= 1'b1; out_d <= '{KIND_UNSUP, func_r, 1'b1, 16'h0};
          job_done <= 1'b1; ph_r <= P_DONE;
        end
        P_WRLO: begin
          ph_r <= bcast ? P_DONE : P_EMIT; job_done <= bcast;
        end
        P_WRM: begin
          // hi_r: 0 addr high issued, 2 capture high, 3 wait, 1 write with low
          if (hi_r == 3'd0) begin hi_r <= 3'd2; fa_r <= fa_r + 1'b1; end
          else if (hi_r == 3'd2) begin wrhi_r <= frd_r; hi_r <= 3'd3; end
          else if (hi_r == 3'd3) hi_r <= 3'd1;
          else begin
            if (17'(emit_r) + 1 == 17'(cnt_r)) begin
              emit_r <= '0; ph_r <= bcast ? P_DONE : P_EMIT; job_done <= bcast;
            end else begin
              emit_r <= emit_r + 1'b1; fa_r <= fa_r + 1'b1; hi_r <= 3'd0;
            end
          end
        end
        P_EMIT: begin
          if (go) begin
            out_valid <= 1'b1;
            out_d <= '{KIND_RESP, nbyte, 1'b0, 16'h0};
            tx_crc_r <= crc_byte(tx_crc_r, nbyte);
            emit_r <= emit_r + 1'b1;
            if (emit_r + 1 == elen_r) ph_r <= P_CRC;
            // wait for the next register's table read before its high byte
            else if (mode_r == M_READ && emit_r >= 2 && !emit_r[0]) ph_r <= P_WAIT;
          end
        end
        P_WAIT: ph_r <= P_EMIT;
        P_CRC: if (go) begin
          out_valid <= 1'b1;
          out_d <= '{KIND_RESP, (emit_r == elen_r) ? tx_crc_r[7:0] : tx_crc_r[15:8],
                     emit_r != elen_r, 16'h0};
          emit_r <= emit_r + 1'b1;
          if (emit_r != elen_r) begin ph_r <= P_DONE; job_done <= 1'b1; end
        end
        default: ;
      endcase
    end
    if (cmd == CMD_RUN && ph_r == P_CHK) begin
      fill_r <= '0; ovf_r <= 1'b0; crc_r <= 16'hFFFF;
    end
    if (!rst_n) begin
      out_valid <= 1'b0; fill_r <= '0; ovf_r <= 1'b0; crc_r <= 16'hFFFF;
      clr_r <= '0; ph_r <= P_DONE; job_done <= 1'b0;
    end
  end
endmodule
